>>> rtl/core/bcel_pkg.sv
package bcel_pkg;

	localparam int unsigned FRAC_BITS = 16;
	localparam int unsigned LN2_Q24 = 24'd11629080;
	localparam int unsigned SUM_W = 40;
	localparam int unsigned MEAN_W = 36;
	localparam int unsigned GRAD_W = 34;
	localparam int unsigned IN_W = 16;
	localparam int unsigned BC_W = 16;

	typedef struct packed {
		logic [IN_W-1:0] p;
		logic [IN_W-1:0] y;
		logic            last;
	} elem_t;

endpackage

>>> rtl/core/bcel_if.sv
interface bcel_in_if;
	logic                         valid;
	logic                         ready;
	logic [bcel_pkg::IN_W-1:0]    predicted;
	logic [bcel_pkg::IN_W-1:0]    target;
	logic                         last_element;
	modport source (output valid, predicted, target, last_element, input ready);
	modport sink (input valid, predicted, target, last_element, output ready);
endinterface

interface bcel_out_if;
	logic                         valid;
	logic                         ready;
	logic [bcel_pkg::GRAD_W-1:0]  gradient;
	logic [bcel_pkg::MEAN_W-1:0]  mean_loss;
	logic                         loss_valid;
	modport source (output valid, gradient, mean_loss, loss_valid, input ready);
	modport sink (input valid, gradient, mean_loss, loss_valid, output ready);
endinterface

>>> rtl/core/bcel_front.sv
// Front: accepts a word, clamps both values into [1, one-1], pushes to a
// two-entry queue.
module bcel_front (
	input  logic                clk,
	input  logic                arst_n,
	bcel_in_if.sink             in_ch,
	output logic                q_valid,
	input  logic                q_pop,
	output bcel_pkg::elem_t     q_data
);
	import bcel_pkg::*;

	localparam logic [IN_W-1:0] ONE_M1 = IN_W'((17'd1 << FRAC_BITS) - 17'd1);

	elem_t     mem_q [2];
	logic      wr_q, rd_q;
	logic [1:0] cnt_q;
	elem_t     e;

	function automatic logic [IN_W-1:0] clamp(input logic [IN_W-1:0] v);
		if (v == '0)
			return IN_W'(1);
		else if (v > ONE_M1)
			return ONE_M1;
		return v;
	endfunction

	always_comb begin
		e.p = clamp(in_ch.predicted);
		e.y = clamp(in_ch.target);
		e.last = in_ch.last_element;
	end

	assign in_ch.ready = (cnt_q != 2'd2);
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	wire push = in_ch.valid && in_ch.ready;
	wire pop  = q_pop && q_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= e;
	end
endmodule

>>> rtl/core/bcel_divu.sv
// Restoring divider, one quotient bit per cycle.
module bcel_divu #(
	parameter int unsigned NW = 40,
	parameter int unsigned DW = 17
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);
	localparam int unsigned CW = $clog2(NW + 1);

	logic [NW-1:0] n_q;
	logic [DW-1:0] d_q;
	logic [DW:0]   rem_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   sh;

	assign sh = {rem_q[DW-1:0], n_q[NW-1]};
	assign quo = n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			d_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (sh >= {1'b0, d_q}) begin
				rem_q <= sh - {1'b0, d_q};
				n_q <= {n_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				n_q <= {n_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

>>> rtl/core/bcel_back.sv
// Back: sequencer running two divides, two logs, the loss accumulate and
// the mean divide on one shared divider and one squaring unit.
module bcel_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_valid,
	output logic                   q_pop,
	input  bcel_pkg::elem_t        q_data,
	input  logic [bcel_pkg::BC_W-1:0] batch_count,
	bcel_out_if.source             out_ch
);
	import bcel_pkg::*;

	localparam int unsigned XW = FRAC_BITS + 1;
	localparam int unsigned NW = SUM_W;
	localparam logic [XW-1:0] ONE = XW'(1) << FRAC_BITS;
	localparam logic [5:0] FB6 = 6'(FRAC_BITS);
	localparam int unsigned NLW = 36;

	typedef enum logic [3:0] {
		S_IDLE, S_DA, S_DB, S_LP, S_LQ, S_LOG, S_LN, S_ACC, S_MEAN, S_OUT
	} st_t;

	st_t           st_q;
	elem_t         e_q;
	logic [XW-1:0] qv_q, rv_q;
	logic [NW-1:0] a_q;
	logic [GRAD_W-1:0] g_q;
	logic [33:0]   z_q;
	logic [29:0]   frac_q;
	logic [4:0]    it_q;
	logic [4:0]    m_q;
	logic [NLW-1:0] nlp_q, nlq_q;
	logic          lsel_q;
	logic [SUM_W-1:0] sum_q;
	logic [MEAN_W-1:0] mean_q;
	logic [67:0]   prod_q;

	logic          d_start, d_done;
	logic [NW-1:0] d_num, d_quo;
	logic [XW-1:0] d_den;

	bcel_divu #(.NW(NW), .DW(XW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(d_start), .num(d_num), .den(d_den),
		.done(d_done), .quo(d_quo)
	);

	logic [XW-1:0] lx;
	logic [4:0]    msb;
	logic [65:0]   sq;
	logic [32:0]   zn;
	logic signed [NW:0] gdiff;
	logic [SUM_W:0] sum_n;

	always_comb begin
		// S_LQ loads the log of 1-p, S_LP the log of p
		lx = (st_q == S_LQ) ? qv_q : {1'b0, e_q.p};
		msb = '0;
		for (int i = 0; i < XW; i++)
			if (lx[i])
				msb = 5'(i);
		sq = z_q[32:0] * z_q[32:0];
		zn = sq[63:31];
		gdiff = $signed({1'b0, a_q}) - $signed({1'b0, d_quo});
	end

	// loss term y*nln(p) + r*nln(q), and the running sum with a carry bit for saturation
	logic [NLW+XW:0] term_full;
	assign term_full = (NLW+XW+1)'(e_q.y) * (NLW+XW+1)'(nlp_q)
		+ (NLW+XW+1)'(rv_q) * (NLW+XW+1)'(nlq_q);
	assign sum_n = {1'b0, sum_q} + (SUM_W+1)'(term_full >> FRAC_BITS);

	always_comb begin
		d_start = 1'b0;
		d_num = '0;
		d_den = XW'(1);
		unique case (st_q)
			S_IDLE: if (q_valid && !out_ch.valid) begin
				d_start = 1'b1;
				d_num = NW'(ONE - {1'b0, q_data.y}) << FRAC_BITS;
				d_den = ONE - {1'b0, q_data.p};
			end
			S_DA: if (d_done) begin
				d_start = 1'b1;
				d_num = NW'(e_q.y) << FRAC_BITS;
				d_den = XW'(e_q.p);
			end
			S_ACC: if (e_q.last) begin
				d_start = 1'b1;
				d_num = sum_n[SUM_W] ? '1 : sum_n[SUM_W-1:0];
				d_den = (batch_count == '0) ? XW'(1) : XW'(batch_count);
			end
			default: ;
		endcase
	end

	assign q_pop = (st_q == S_IDLE) && q_valid && !out_ch.valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			out_ch.valid <= 1'b0;
			sum_q <= '0;
			lsel_q <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready)
				out_ch.valid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (q_pop)
					st_q <= S_DA;
				S_DA: if (d_done)
					st_q <= S_DB;
				S_DB: if (d_done)
					st_q <= S_LP;
				S_LP: begin
					lsel_q <= 1'b0;
					st_q <= S_LOG;
				end
				S_LQ: begin
					lsel_q <= 1'b1;
					st_q <= S_LOG;
				end
				S_LOG: if (it_q == 5'd30)
					st_q <= S_LN;
				S_LN: st_q <= lsel_q ? S_ACC : S_LQ;
				S_ACC: begin
					if (e_q.last) begin
						sum_q <= '0;
						st_q <= S_MEAN;
					end else begin
						sum_q <= sum_n[SUM_W] ? '1 : sum_n[SUM_W-1:0];
						st_q <= S_OUT;
					end
				end
				S_MEAN: if (d_done)
					st_q <= S_OUT;
				S_OUT: begin
					out_ch.valid <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			e_q <= q_data;
			qv_q <= ONE - {1'b0, q_data.p};
			rv_q <= ONE - {1'b0, q_data.y};
			mean_q <= '0;
		end
		if (st_q == S_DA && d_done)
			a_q <= d_quo;
		if (st_q == S_DB && d_done) begin
			if (gdiff > $signed((NW+1)'(34'h1_FFFF_FFFF)))
				g_q <= {1'b0, {(GRAD_W-1){1'b1}}};
			else if (gdiff < -$signed((NW+1)'(35'h2_0000_0000)))
				g_q <= {1'b1, {(GRAD_W-1){1'b0}}};
			else
				g_q <= gdiff[GRAD_W-1:0];
		end
		if (st_q == S_LP || st_q == S_LQ) begin
			z_q <= 34'({lx, 31'd0} >> msb);
			m_q <= msb;
			frac_q <= '0;
			it_q <= '0;
		end
		if (st_q == S_LOG && it_q != 5'd30) begin
			it_q <= it_q + 1'b1;
			if (zn[32]) begin
				z_q <= {2'b0, zn[32:1]};
				frac_q[5'd29 - it_q] <= 1'b1;
			end else
				z_q <= {1'b0, zn};
		end
		if (st_q == S_LOG && it_q == 5'd30) begin
			prod_q <= 68'((({30'd0, FB6 - {1'b0, m_q}}) << 30) - {36'd0, frac_q})
				* 68'(LN2_Q24);
		end
		if (st_q == S_LN) begin
			if (lsel_q)
				nlq_q <= NLW'(prod_q >> (54 - FRAC_BITS));
			else
				nlp_q <= NLW'(prod_q >> (54 - FRAC_BITS));
		end
		if (st_q == S_MEAN && d_done)
			mean_q <= (d_quo > NW'({MEAN_W{1'b1}})) ? '1 : d_quo[MEAN_W-1:0];
		if (st_q == S_OUT) begin
			out_ch.gradient <= g_q;
			out_ch.mean_loss <= mean_q;
			out_ch.loss_valid <= e_q.last;
		end
	end
endmodule

>>> rtl/core/bce_loss_and_gradient_core.sv
// Binary cross-entropy loss/gradient. One word of (predicted, target, last)
// yields one result word: the gradient, and on the last word the mean loss.
// Words are handled one at a time, and the back takes no new word while a result
// is still waiting to be taken. Each word runs two passes of the shared bit-serial
// divider, two log2 squaring runs and the sequencing states, and on the last word
// a third divider pass for the mean. A two-word queue lets the front keep accepting
// while the back works. batch_count is written via cfg_we.
module bce_loss_and_gradient_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	bcel_in_if.sink     in_ch,
	bcel_out_if.source  out_ch
);
	import bcel_pkg::*;

	logic [BC_W-1:0] bc_q;
	logic            qv, qp;
	elem_t           qd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bc_q <= BC_W'(1);
		else if (cfg_we)
			bc_q <= cfg_wdata;
	end

	bcel_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch),
		.q_valid(qv), .q_pop(qp), .q_data(qd)
	);

	bcel_back u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(qv), .q_pop(qp), .q_data(qd),
		.batch_count(bc_q), .out_ch(out_ch)
	);
endmodule

>>> rtl/core/bcel_checker.sv
module bcel_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [35:0] mean_loss,
	input logic        loss_valid
);
	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !loss_valid |-> mean_loss == '0) else $error("mean not zero");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid) else $error("valid dropped");
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid) else $error("result too soon");
endmodule

bind bce_loss_and_gradient_core bcel_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.mean_loss(out_ch.mean_loss), .loss_valid(out_ch.loss_valid)
);
